// File: src/xtea_block_cipher_core_macros.svh
// Assertion macros shared by the XTEA core RTL.
`ifndef XTEA_BLOCK_CIPHER_CORE_MACROS_SVH
`define XTEA_BLOCK_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define XT_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define XT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/xtea_pkg.sv
// Shared types, constants and round helpers for the XTEA core.
`default_nettype none

package xtea_pkg;

	// Round constant
	localparam logic [31:0] XT_DELTA = 32'h9e3779b9;

	// Operation select
	typedef enum logic {
		FUNC_ENC = 1'b0,
		FUNC_DEC = 1'b1
	} func_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_KEY_WORD_0 = 2'd0,
		REG_KEY_WORD_1 = 2'd1,
		REG_KEY_WORD_2 = 2'd2,
		REG_KEY_WORD_3 = 2'd3
	} cfg_reg_t;

	// Shift/xor/add mixing term of one half-round
	function automatic logic [31:0] xt_mix(input logic [31:0] v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	// Running sum after m steps of delta, 32-bit wrap
	function automatic logic [31:0] xt_sum_at(input int unsigned m);
		logic [63:0] prod;
		prod = 64'(m) * 64'(XT_DELTA);
		return prod[31:0];
	endfunction

endpackage

`default_nettype wire

// File: src/xtea_if.sv
// Valid/ready channel interfaces: block in, result out, key write port.
`default_nettype none

// Input block channel
interface xtea_blk_if import xtea_pkg::*; ();
	logic        valid;
	logic        ready;
	func_t       func;
	logic [31:0] block_first;
	logic [31:0] block_second;

	modport source (output valid, output func, output block_first, output block_second,
		input ready);
	modport sink (input valid, input func, input block_first, input block_second,
		output ready);
endinterface

// Result block channel
interface xtea_res_if ();
	logic        valid;
	logic        ready;
	logic [31:0] result_first;
	logic [31:0] result_second;

	modport source (output valid, output result_first, output result_second, input ready);
	modport sink (input valid, input result_first, input result_second, output ready);
endinterface

// Key register write channel
interface xtea_cfg_if import xtea_pkg::*; ();
	logic        valid;
	logic        ready;
	cfg_reg_t    index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/xtea_block_cipher_core.sv
// XTEA block cipher core: fully unrolled half-round pipeline, one block per clock.
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------
//   blk_in   | in  | func, block_first, block_second
//   blk_out  | out | result_first, result_second
//   cfg      | in  | index (key word 0..3), data (32-bit key word)
//
// Each of the 2*ROUND_CYCLES stages does one half-round (one mix add, one add or
// subtract) and registers it, so a block passes every stage from input to result.
// One beat per clock is taken while blk_out is ready; stage count sets latency.
// Reset clears the stage valid bits and the key words to zero; cfg is always ready.
// A stalled result holds in the last stage while empty stages ahead keep filling.
`default_nettype none
`include "xtea_block_cipher_core_macros.svh"

module xtea_block_cipher_core
	import xtea_pkg::*;
#(
	parameter int ROUND_CYCLES = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	xtea_blk_if.sink      blk_in,
	xtea_res_if.source    blk_out,
	xtea_cfg_if.sink      cfg
);

	localparam int NST  = 2 * ROUND_CYCLES;
	localparam int LAST = NST - 1;

	// Key words
	logic [31:0] key_q [4];

	// Stage registers
	logic        v_s    [NST];
	func_t       func_s [NST];
	logic [31:0] w0_s   [NST];
	logic [31:0] w1_s   [NST];

	// Per-stage ready, rdy[k] means stage k may load this cycle
	logic [NST:0] rdy;

	// Key register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= '0;
			key_q[1] <= '0;
			key_q[2] <= '0;
			key_q[3] <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KEY_WORD_0: key_q[0] <= cfg.data;
				REG_KEY_WORD_1: key_q[1] <= cfg.data;
				REG_KEY_WORD_2: key_q[2] <= cfg.data;
				REG_KEY_WORD_3: key_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Ready chain: a stage loads when empty or when its content moves on
	assign rdy[NST]     = blk_out.ready;
	assign blk_in.ready = rdy[0];

	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_stage
			localparam int          N      = k / 2;
			localparam bit          ODD    = (k % 2) == 1;
			localparam logic [31:0] ENC_SUM = xt_sum_at(ODD ? N + 1 : N);
			localparam logic [31:0] DEC_SUM = xt_sum_at(ODD ? ROUND_CYCLES - N - 1
				: ROUND_CYCLES - N);
			// enc even and dec odd use sum[1:0], the others sum[12:11]
			localparam logic [1:0]  ENC_KI = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
			localparam logic [1:0]  DEC_KI = ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

			logic        src_v;
			func_t       src_func;
			logic [31:0] src_w0;
			logic [31:0] src_w1;
			logic        upd_first;
			logic [31:0] opnd;
			logic [31:0] tgt;
			logic [31:0] sum;
			logic [31:0] key;
			logic [31:0] fterm;
			logic [31:0] new_val;

			assign rdy[k] = !v_s[k] || rdy[k+1];

			// Stage source
			if (k == 0) begin : g_src_in
				assign src_v    = blk_in.valid;
				assign src_func = blk_in.func;
				assign src_w0   = blk_in.block_first;
				assign src_w1   = blk_in.block_second;
			end else begin : g_src_prev
				assign src_v    = v_s[k-1];
				assign src_func = func_s[k-1];
				assign src_w0   = w0_s[k-1];
				assign src_w1   = w1_s[k-1];
			end

			// Half-round: encrypt updates first half on even stages, decrypt on odd
			always_comb begin
				upd_first = (src_func == FUNC_ENC) ^ ODD;
				opnd      = upd_first ? src_w1 : src_w0;
				tgt       = upd_first ? src_w0 : src_w1;
				sum       = (src_func == FUNC_ENC) ? ENC_SUM : DEC_SUM;
				key       = (src_func == FUNC_ENC) ? key_q[ENC_KI] : key_q[DEC_KI];
				fterm     = xt_mix(opnd) ^ (sum + key);
				new_val   = (src_func == FUNC_ENC) ? tgt + fterm : tgt - fterm;
			end

			// Valid bit
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					v_s[k] <= src_v;
				end
			end

			// Payload
			always_ff @(posedge clk) begin
				if (rdy[k] && src_v) begin
					func_s[k] <= src_func;
					w0_s[k]   <= upd_first ? new_val : src_w0;
					w1_s[k]   <= upd_first ? src_w1 : new_val;
				end
			end
		end
	endgenerate

	// Result channel
	assign blk_out.valid         = v_s[LAST];
	assign blk_out.result_first  = w0_s[LAST];
	assign blk_out.result_second = w1_s[LAST];

	// Checks
	`XT_ASSERT_IMP(a_in_ready_when_empty, !v_s[0], blk_in.ready,
		"input not ready with first stage empty")
	`XT_ASSERT_IMP(a_flow_when_out_ready, blk_out.ready, blk_in.ready,
		"pipeline stalled while result side is ready")
	`XT_ASSERT_NEXT(a_in_beat_lands, blk_in.valid && blk_in.ready,
		v_s[0] && func_s[0] == $past(blk_in.func),
		"accepted beat missing from first stage")
	`XT_ASSERT_NEXT(a_stage_holds, v_s[0] && !rdy[1],
		v_s[0] && $stable(w0_s[0]) && $stable(w1_s[0]),
		"stalled first stage changed")

endmodule

`default_nettype wire

// File: tb/sv/xtea_result_checker.sv
// Result checker for the XTEA core: mirrors the key registers, predicts each block, compares.
`timescale 1ns / 100ps

module xtea_result_checker
	import xtea_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	// block input channel
	input  wire         in_valid,
	input  wire         in_ready,
	input  func_t       in_func,
	input  wire  [31:0] in_first,
	input  wire  [31:0] in_second,
	// result channel
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [31:0] out_first,
	input  wire  [31:0] out_second,
	// key write channel
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  cfg_reg_t    cfg_index,
	input  wire  [31:0] cfg_data,
	// end of run: flag any block still owed
	input  wire         wrap_up,
	output int          fail_count,
	output int          pending
);

	localparam int ROUNDS = 32;

	typedef struct packed {
		logic [31:0] first;
		logic [31:0] second;
	} cipher_block_t;

	logic [31:0]   key_words [4];
	cipher_block_t expected_blocks [$];
	cipher_block_t want;
	int            result_idx;
	bit            wrapped;

	// Shift/xor/add term that feeds each half-round
	function automatic logic [31:0] mix_term(input logic [31:0] v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	// Full XTEA (ROUNDS iterations of both half-rounds) on one block under the current key copy
	function automatic cipher_block_t xtea_cipher_block(input func_t op,
		input logic [31:0] first_in, input logic [31:0] second_in);
		logic [31:0]   v0;
		logic [31:0]   v1;
		logic [31:0]   sum;
		cipher_block_t blk;
		v0 = first_in;
		v1 = second_in;
		if (op == FUNC_ENC) begin
			sum = '0;
			for (int r = 0; r < ROUNDS; r++) begin
				v0 += mix_term(v1) ^ (sum + key_words[sum[1:0]]);
				sum += XT_DELTA;
				v1 += mix_term(v0) ^ (sum + key_words[sum[12:11]]);
			end
		end else begin
			// decrypt walks the sum back down from delta * rounds (32-bit wrap)
			sum = XT_DELTA * 32'(ROUNDS);
			for (int r = 0; r < ROUNDS; r++) begin
				v1 -= mix_term(v0) ^ (sum + key_words[sum[12:11]]);
				sum -= XT_DELTA;
				v0 -= mix_term(v1) ^ (sum + key_words[sum[1:0]]);
			end
		end
		blk.first  = v0;
		blk.second = v1;
		return blk;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		fail_count++;
	endtask

	// Watch all three channels; one beat per channel per edge at most
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_words = '{default: '0};
			expected_blocks.delete();
			result_idx = 0;
			wrapped = 1'b0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				key_words[cfg_index] = cfg_data;

			if (in_valid && in_ready)
				expected_blocks.push_back(xtea_cipher_block(in_func, in_first, in_second));

			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch($sformatf("result %0d (%h %h) with no block pending",
						result_idx, out_first, out_second));
				end else begin
					want = expected_blocks.pop_front();
					if (out_first !== want.first)
						report_mismatch($sformatf("result %0d result_first %h, want %h",
							result_idx, out_first, want.first));
					if (out_second !== want.second)
						report_mismatch($sformatf("result %0d result_second %h, want %h",
							result_idx, out_second, want.second));
				end
				result_idx++;
			end

			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (expected_blocks.size() != 0)
					report_mismatch($sformatf("%0d blocks never came out",
						expected_blocks.size()));
			end

			pending = expected_blocks.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the XTEA core: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 100ps

module tb_top
	import xtea_pkg::*;
();

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 238;
	localparam int PIPE_LATENCY    = 64;
	localparam int DRAIN_LIMIT     = 50000;

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	logic wrap_up = 1'b0;
	int   fail_count;
	int   pending;
	int   src_idle_pct   = 0;
	int   sink_stall_pct = 0;

	// directed corner blocks, each sent both ways
	logic [31:0] corner_first  [5] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
		32'h0000_0001, 32'haaaa_aaaa};
	logic [31:0] corner_second [5] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
		32'h8000_0000, 32'h5555_5555};
	cfg_reg_t    key_regs      [4] = '{REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2,
		REG_KEY_WORD_3};

	always #2 clk = ~clk;

	xtea_blk_if blk_if ();
	xtea_res_if res_if ();
	xtea_cfg_if cfg_if ();

	xtea_block_cipher_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk_in  (blk_if),
		.blk_out (res_if),
		.cfg     (cfg_if)
	);

	xtea_result_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (blk_if.valid),
		.in_ready   (blk_if.ready),
		.in_func    (blk_if.func),
		.in_first   (blk_if.block_first),
		.in_second  (blk_if.block_second),
		.out_valid  (res_if.valid),
		.out_ready  (res_if.ready),
		.out_first  (res_if.result_first),
		.out_second (res_if.result_second),
		.cfg_valid  (cfg_if.valid),
		.cfg_ready  (cfg_if.ready),
		.cfg_index  (cfg_if.index),
		.cfg_data   (cfg_if.data),
		.wrap_up    (wrap_up),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Result side backpressure
	always @(negedge clk) begin
		res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Hard stop for a hung run
	initial begin
		#2_000_000;
		$display("** xtea_block_cipher_core: FAILED **");
		$finish;
	end

	// Mostly random words, with the all-zero and all-one extremes mixed in
	function automatic logic [31:0] pick_word();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// One block beat; random gaps ahead of it, held until accepted
	task automatic send_block(input func_t op, input logic [31:0] w0, input logic [31:0] w1);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			blk_if.valid <= 1'b0;
			@(negedge clk);
		end
		blk_if.valid        <= 1'b1;
		blk_if.func         <= op;
		blk_if.block_first  <= w0;
		blk_if.block_second <= w1;
		do @(posedge clk); while (!blk_if.ready);
	endtask

	// Write all four key words, back to back
	task automatic write_key_set(input logic [31:0] keys [4]);
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_if.valid <= 1'b1;
			cfg_if.index <= key_regs[i];
			cfg_if.data  <= keys[i];
			do @(posedge clk); while (!cfg_if.ready);
		end
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Every block sent so far has come back
	task automatic wait_for_results();
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [31:0] keys [4];

		blk_if.valid        = 1'b0;
		blk_if.func         = FUNC_ENC;
		blk_if.block_first  = '0;
		blk_if.block_second = '0;
		res_if.ready        = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = REG_KEY_WORD_0;
		cfg_if.data         = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// idle mode: none, sender gaps, result stalls, both
			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
				default: begin src_idle_pct = 23; sink_stall_pct = 23; end
			endcase

			// key setting for this phase; phase 0 runs on the reset keys
			if (ph != 0) begin
				case (ph)
					1: keys = '{default: 32'hffff_ffff};
					2: keys = '{default: 32'h0000_0000};
					3: keys = '{32'h0001_0203, 32'h0405_0607, 32'h0809_0a0b, 32'h0c0d_0e0f};
					5: keys = '{32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000};
					default: keys = '{$urandom, $urandom, $urandom, $urandom};
				endcase
				write_key_set(keys);
			end

			// directed corners under the zero and the all-ones key
			if (ph < 2) begin
				for (int c = 0; c < 5; c++) begin
					send_block(FUNC_ENC, corner_first[c], corner_second[c]);
					send_block(FUNC_DEC, corner_first[c], corner_second[c]);
				end
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_block($urandom_range(1) ? FUNC_DEC : FUNC_ENC, pick_word(), pick_word());

			@(negedge clk);
			blk_if.valid <= 1'b0;
			wait_for_results();
		end

		// final drain, bounded, then a quiet spell before wrap-up
		for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++)
			@(negedge clk);
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		@(negedge clk);
		wrap_up <= 1'b1;
		@(posedge clk);
		@(negedge clk);

		if (fail_count == 0)
			$display("** xtea_block_cipher_core: PASSED **");
		else
			$display("** xtea_block_cipher_core: FAILED **");
		$finish;
	end

endmodule
